// ----- hdl/bfa_pkg.sv -----
// Shared widths, operation and status codes, and controller/datapath command types.
package bfa_pkg;

   // Field widths of the request, response and register channels.
   localparam int FRAME_W    = 20;
   localparam int FUNC_W     = 2;
   localparam int COUNT_W    = 11;
   localparam int STATUS_W   = 2;
   localparam int SIZE_W     = 11;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 20;

   // Operation codes carried by the request func field.
   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RESERVE = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_OUTSIDE = 2'd2;

   // Register indexes and the reset value of the pool size register.
   localparam logic [CSR_ADDR_W-1:0] CSR_POOL_BASE = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_POOL_SIZE = 1'd1;
   localparam logic [SIZE_W-1:0]     POOL_SIZE_RESET = 11'd1024;

   // One datapath operation per cycle, chosen by the controller.
   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD_REQ,
      DP_SCAN_INIT,
      DP_SCAN_NEXT,
      DP_ALLOC_COMMIT,
      DP_ALLOC_FAIL,
      DP_SET_OUTSIDE,
      DP_DIV_START,
      DP_DIV_LOAD,
      DP_REL_READ,
      DP_REL_WRITE,
      DP_RES_STEP,
      DP_FLUSH_READ,
      DP_FLUSH_WRITE,
      DP_OUT_LOAD,
      DP_CLEAR
   } dp_op_type;

   // Conditions the datapath reports back to the controller.
   typedef struct packed {
      logic scan_found;
      logic scan_last;
      logic in_pool;
      logic left_zero;
      logic left_one;
      logic step_flush;
      logic clear_last;
   } dp_stat_type;

endpackage

// ----- hdl/bfa_if.sv -----
// Valid/ready channel interfaces for requests, responses and register writes.
interface bfa_req_if;
   logic                         valid;
   logic                         ready;
   logic [bfa_pkg::FUNC_W-1:0]   func;
   logic [bfa_pkg::FRAME_W-1:0]  first_frame;
   logic [bfa_pkg::COUNT_W-1:0]  frame_count;

   modport source (output valid, output func, output first_frame, output frame_count,
                   input ready);
   modport sink (input valid, input func, input first_frame, input frame_count,
                 output ready);
endinterface

interface bfa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bfa_pkg::FRAME_W-1:0]   frame_no;
   logic [bfa_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output frame_no, output status, input ready);
   modport sink (input valid, input frame_no, input status, output ready);
endinterface

interface bfa_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bfa_pkg::CSR_ADDR_W-1:0]  addr;
   logic [bfa_pkg::CSR_DATA_W-1:0]  wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink (input valid, input addr, input wdata, output ready);
endinterface

// ----- hdl/bitmap_frame_allocator_unit.sv -----
// Top level of the bitmap frame allocator: controller, datapath and channel ports.
//
// The allocator keeps one used bit per frame of the pool in a map RAM of
// POOL_FRAMES/WORD_BITS words, MSB-first within a word, and serves one request at
// a time. Allocate reads one map word per cycle through the RAM read port. Release
// first splits the frame offset into word and bit with a multiply by the reciprocal
// of WORD_BITS, then reads and rewrites the map word. Reserve makes the same split
// when its run starts inside the pool, then walks one frame per cycle, pausing for a
// read-modify-write of each map word it touches. A finished result sits in an output
// register while the next request is taken. After reset a clearing pass writes the
// map to zero; requests are held off during that time, while register writes are
// taken at any time.
module bitmap_frame_allocator_unit #(
   parameter int POOL_FRAMES = 1024,
   parameter int WORD_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   bfa_req_if.sink     req_bus,
   bfa_rsp_if.source   rsp_bus,
   bfa_csr_if.sink     csr_bus
);

   bfa_pkg::dp_op_type    cmd;
   bfa_pkg::dp_stat_type  stat;

   // Sequencer.
   bfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_func  (req_bus.func),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Map storage and arithmetic.
   bfa_dpath #(
      .POOL_FRAMES (POOL_FRAMES),
      .WORD_BITS   (WORD_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_first_frame (req_bus.first_frame),
      .req_frame_count (req_bus.frame_count),
      .rsp_frame_no    (rsp_bus.frame_no),
      .rsp_status      (rsp_bus.status),
      .csr_bus         (csr_bus),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

// ----- hdl/bfa_ctrl.sv -----
// Sequencing state machine that steps the allocator datapath through each operation.
module bfa_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [bfa_pkg::FUNC_W-1:0]  req_func,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output bfa_pkg::dp_op_type          cmd,
   input  bfa_pkg::dp_stat_type        stat
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_DIV,
      ST_REL_RD,
      ST_REL_WR,
      ST_RES_STEP,
      ST_FLUSH_RD,
      ST_FLUSH_WR,
      ST_DONE
   } state_type;

   state_type                   state_ff, state_in;
   logic [bfa_pkg::FUNC_W-1:0]  func_ff;
   logic                        rsp_valid_ff;
   logic                        load_out;

   // Requests are taken only between operations.
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and the datapath command for this cycle.
   always_comb begin
      state_in = state_ff;
      cmd      = bfa_pkg::DP_NONE;
      load_out = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd = bfa_pkg::DP_CLEAR;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd      = bfa_pkg::DP_LOAD_REQ;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (func_ff)
               bfa_pkg::FUNC_ALLOC: begin
                  cmd      = bfa_pkg::DP_SCAN_INIT;
                  state_in = ST_SCAN;
               end
               bfa_pkg::FUNC_RELEASE: begin
                  if (stat.in_pool) begin
                     cmd      = bfa_pkg::DP_DIV_START;
                     state_in = ST_DIV;
                  end else begin
                     cmd      = bfa_pkg::DP_SET_OUTSIDE;
                     state_in = ST_DONE;
                  end
               end
               bfa_pkg::FUNC_RESERVE: begin
                  if (stat.left_zero) begin
                     state_in = ST_DONE;
                  end else if (stat.in_pool) begin
                     cmd      = bfa_pkg::DP_DIV_START;
                     state_in = ST_DIV;
                  end else begin
                     state_in = ST_RES_STEP;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_SCAN: begin
            if (stat.scan_found) begin
               cmd      = bfa_pkg::DP_ALLOC_COMMIT;
               state_in = ST_DONE;
            end else if (stat.scan_last) begin
               cmd      = bfa_pkg::DP_ALLOC_FAIL;
               state_in = ST_DONE;
            end else begin
               cmd = bfa_pkg::DP_SCAN_NEXT;
            end
         end
         ST_DIV: begin
            // The word index is registered; split off the bit position now.
            cmd      = bfa_pkg::DP_DIV_LOAD;
            state_in = (func_ff == bfa_pkg::FUNC_RELEASE) ? ST_REL_RD : ST_RES_STEP;
         end
         ST_REL_RD: begin
            cmd      = bfa_pkg::DP_REL_READ;
            state_in = ST_REL_WR;
         end
         ST_REL_WR: begin
            cmd      = bfa_pkg::DP_REL_WRITE;
            state_in = ST_DONE;
         end
         ST_RES_STEP: begin
            cmd = bfa_pkg::DP_RES_STEP;
            if (stat.step_flush) begin
               state_in = ST_FLUSH_RD;
            end else if (stat.left_one) begin
               state_in = ST_DONE;
            end
         end
         ST_FLUSH_RD: begin
            cmd      = bfa_pkg::DP_FLUSH_READ;
            state_in = ST_FLUSH_WR;
         end
         ST_FLUSH_WR: begin
            cmd      = bfa_pkg::DP_FLUSH_WRITE;
            state_in = stat.left_zero ? ST_DONE : ST_RES_STEP;
         end
         ST_DONE: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd      = bfa_pkg::DP_OUT_LOAD;
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, latched operation code and response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_valid && req_ready) begin
         func_ff <= req_func;
      end
   end

endmodule

// ----- hdl/bfa_dpath.sv -----
// Allocator datapath: used-bit map RAM, scan, offset split, run walker and registers.
module bfa_dpath #(
   parameter int POOL_FRAMES = 1024,
   parameter int WORD_BITS   = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bfa_pkg::FRAME_W-1:0]    req_first_frame,
   input  logic [bfa_pkg::COUNT_W-1:0]    req_frame_count,
   output logic [bfa_pkg::FRAME_W-1:0]    rsp_frame_no,
   output logic [bfa_pkg::STATUS_W-1:0]   rsp_status,
   bfa_csr_if.sink                        csr_bus,
   input  bfa_pkg::dp_op_type             cmd,
   output bfa_pkg::dp_stat_type           stat
);

   localparam int MAP_WORDS = (POOL_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int OFF_W     = $clog2(POOL_FRAMES);
   localparam int EFF_W     = $clog2(POOL_FRAMES + 1);
   localparam int EXT_W     = (EFF_W > bfa_pkg::SIZE_W) ? EFF_W : bfa_pkg::SIZE_W;
   localparam int DIV_SH    = OFF_W + BIT_W;
   localparam int PROD_W    = 2 * OFF_W + 1;

   localparam logic [BIT_W-1:0]           BIT_LAST  = BIT_W'(WORD_BITS - 1);
   localparam logic [WORD_W-1:0]          WORD_LAST = WORD_W'(MAP_WORDS - 1);
   localparam logic [EFF_W-1:0]           EFF_MAX   = EFF_W'(POOL_FRAMES);
   localparam logic [EFF_W-1:0]           WB_EFF    = EFF_W'(WORD_BITS);
   localparam logic [bfa_pkg::FRAME_W-1:0] WB_FRAME = bfa_pkg::FRAME_W'(WORD_BITS);
   localparam logic [OFF_W-1:0]           WB_OFF    = OFF_W'(WORD_BITS);
   // Rounded-up reciprocal of WORD_BITS; exact for every offset below 2^OFF_W.
   localparam logic [PROD_W-1:0]          DIV_RCP   =
      PROD_W'(((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS);

   // Pool size register clamped to the capacity of the map.
   function automatic logic [EFF_W-1:0] clamp_size(input logic [bfa_pkg::SIZE_W-1:0] size);
      if (EXT_W'(size) > EXT_W'(POOL_FRAMES)) begin
         return EFF_MAX;
      end
      return EFF_W'(size);
   endfunction

   // Configuration.
   logic [bfa_pkg::FRAME_W-1:0]  base_ff;
   logic [EFF_W-1:0]             eff_ff;

   // Request working registers and result.
   logic [bfa_pkg::FRAME_W-1:0]  off_ff;
   logic [bfa_pkg::COUNT_W-1:0]  left_ff;
   logic [bfa_pkg::FRAME_W-1:0]  res_frame_ff;
   logic [bfa_pkg::STATUS_W-1:0] res_status_ff;
   logic [bfa_pkg::FRAME_W-1:0]  out_frame_ff;
   logic [bfa_pkg::STATUS_W-1:0] out_status_ff;

   // Scan state.
   logic [WORD_W-1:0]            scan_word_ff;
   logic [EFF_W-1:0]             remain_ff;
   logic [bfa_pkg::FRAME_W-1:0]  woff_ff;

   // Word/bit position of the current frame, pending set mask for reserve.
   logic [WORD_W-1:0]            word_ff;
   logic [BIT_W-1:0]             bit_ff;
   logic [WORD_W-1:0]            fl_word_ff;
   logic [WORD_BITS-1:0]         mask_ff;

   // Offset split and clearing sweep.
   logic [WORD_W-1:0]            div_q_ff;
   logic [WORD_W-1:0]            clr_addr_ff;

   // Map RAM.
   logic [WORD_BITS-1:0]         map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0]         rdata_ff;
   logic                         mem_we, mem_re;
   logic [WORD_W-1:0]            mem_waddr, mem_raddr;
   logic [WORD_BITS-1:0]         mem_wdata;

   // Combinational helpers.
   logic [WORD_BITS-1:0]         free_rev, lowest, set_word, frame_sel;
   logic [BIT_W-1:0]             free_idx;
   logic [bfa_pkg::FRAME_W-1:0]  eff_frame, off_next;
   logic                         in_pool;
   logic [PROD_W-1:0]            div_prod;
   logic [OFF_W-1:0]             div_base;

   assign csr_bus.ready = 1'b1;
   assign rsp_frame_no  = out_frame_ff;
   assign rsp_status    = out_status_ff;

   assign eff_frame = bfa_pkg::FRAME_W'(eff_ff);
   assign in_pool   = (off_ff < eff_frame);
   assign off_next  = off_ff + 1'b1;
   assign frame_sel = {{(WORD_BITS - 1){1'b0}}, 1'b1} << (BIT_LAST - bit_ff);

   // Free bits of the scanned word, reordered so index j is frame offset j of the word.
   // Bits past the end of the pool count as used.
   always_comb begin
      free_rev = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         free_rev[j] = (EFF_W'(j) < remain_ff) & ~rdata_ff[WORD_BITS - 1 - j];
      end
   end

   // Isolate the lowest free offset and encode it.
   assign lowest = free_rev & (~free_rev + 1'b1);

   always_comb begin
      set_word = '0;
      free_idx = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         set_word[WORD_BITS - 1 - j] = lowest[j];
         free_idx = free_idx | (lowest[j] ? BIT_W'(j) : '0);
      end
   end

   // Word index by reciprocal multiplication, bit position as what is left over.
   assign div_prod = PROD_W'(off_ff[OFF_W-1:0]) * DIV_RCP;
   assign div_base = OFF_W'(div_q_ff) * WB_OFF;

   // Status for the controller.
   always_comb begin
      stat.scan_found = |free_rev;
      stat.scan_last  = (remain_ff <= WB_EFF);
      stat.in_pool    = in_pool;
      stat.left_zero  = (left_ff == '0);
      stat.left_one   = (left_ff == bfa_pkg::COUNT_W'(1));
      stat.step_flush = in_pool && ((bit_ff == BIT_LAST) || (off_next == eff_frame) ||
                                    (left_ff == bfa_pkg::COUNT_W'(1)));
      stat.clear_last = (clr_addr_ff == WORD_LAST);
   end

   // Map RAM port selection.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = scan_word_ff;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = scan_word_ff;
      case (cmd)
         bfa_pkg::DP_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
         end
         bfa_pkg::DP_SCAN_INIT: begin
            mem_re    = 1'b1;
            mem_raddr = '0;
         end
         bfa_pkg::DP_SCAN_NEXT: begin
            mem_re    = 1'b1;
            mem_raddr = scan_word_ff + 1'b1;
         end
         bfa_pkg::DP_ALLOC_COMMIT: begin
            mem_we    = 1'b1;
            mem_wdata = rdata_ff | set_word;
         end
         bfa_pkg::DP_REL_READ: begin
            mem_re    = 1'b1;
            mem_raddr = word_ff;
         end
         bfa_pkg::DP_REL_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = word_ff;
            mem_wdata = rdata_ff & ~frame_sel;
         end
         bfa_pkg::DP_FLUSH_READ: begin
            mem_re    = 1'b1;
            mem_raddr = fl_word_ff;
         end
         bfa_pkg::DP_FLUSH_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = fl_word_ff;
            mem_wdata = rdata_ff | mask_ff;
         end
         default: begin
         end
      endcase
   end

   // Map RAM with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= map_mem[mem_raddr];
      end
   end

   // Configuration registers and clearing sweep address.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= '0;
         eff_ff      <= clamp_size(bfa_pkg::POOL_SIZE_RESET);
         clr_addr_ff <= '0;
      end else begin
         if (csr_bus.valid) begin
            case (csr_bus.addr)
               bfa_pkg::CSR_POOL_BASE: base_ff <= csr_bus.wdata;
               bfa_pkg::CSR_POOL_SIZE: eff_ff <= clamp_size(csr_bus.wdata[bfa_pkg::SIZE_W-1:0]);
               default: begin
               end
            endcase
         end
         if (cmd == bfa_pkg::DP_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   // Registered word index of the current offset.
   always_ff @(posedge clock) begin
      if (cmd == bfa_pkg::DP_DIV_START) begin
         div_q_ff <= WORD_W'(div_prod >> DIV_SH);
      end
   end

   // Request, scan, walk and result registers.
   always_ff @(posedge clock) begin
      case (cmd)
         bfa_pkg::DP_LOAD_REQ: begin
            off_ff        <= req_first_frame - base_ff;
            left_ff       <= req_frame_count;
            res_frame_ff  <= req_first_frame;
            res_status_ff <= bfa_pkg::STAT_OK;
            mask_ff       <= '0;
         end
         bfa_pkg::DP_SCAN_INIT: begin
            scan_word_ff <= '0;
            remain_ff    <= eff_ff;
            woff_ff      <= '0;
         end
         bfa_pkg::DP_SCAN_NEXT: begin
            scan_word_ff <= scan_word_ff + 1'b1;
            remain_ff    <= remain_ff - WB_EFF;
            woff_ff      <= woff_ff + WB_FRAME;
         end
         bfa_pkg::DP_ALLOC_COMMIT: begin
            res_frame_ff  <= base_ff + woff_ff + bfa_pkg::FRAME_W'(free_idx);
            res_status_ff <= bfa_pkg::STAT_OK;
         end
         bfa_pkg::DP_ALLOC_FAIL: begin
            res_frame_ff  <= '0;
            res_status_ff <= bfa_pkg::STAT_FULL;
         end
         bfa_pkg::DP_SET_OUTSIDE: begin
            res_status_ff <= bfa_pkg::STAT_OUTSIDE;
         end
         bfa_pkg::DP_DIV_LOAD: begin
            word_ff <= div_q_ff;
            bit_ff  <= BIT_W'(off_ff[OFF_W-1:0] - div_base);
         end
         bfa_pkg::DP_RES_STEP: begin
            // Mark one frame of the run (or flag the result as outside the pool) and move to the next frame number.
            if (in_pool) begin
               mask_ff    <= mask_ff | frame_sel;
               fl_word_ff <= word_ff;
            end else begin
               res_status_ff <= bfa_pkg::STAT_OUTSIDE;
            end
            off_ff  <= off_next;
            left_ff <= left_ff - 1'b1;
            if (off_next == '0) begin
               word_ff <= '0;
               bit_ff  <= '0;
            end else if (in_pool) begin
               if (bit_ff == BIT_LAST) begin
                  bit_ff  <= '0;
                  word_ff <= word_ff + 1'b1;
               end else begin
                  bit_ff <= bit_ff + 1'b1;
               end
            end
         end
         bfa_pkg::DP_FLUSH_WRITE: begin
            mask_ff <= '0;
         end
         bfa_pkg::DP_OUT_LOAD: begin
            out_frame_ff  <= res_frame_ff;
            out_status_ff <= res_status_ff;
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- hdl/bfa_checker.sv -----
// Port-level assertions for the frame allocator and the bind that attaches them.
module bfa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bfa_pkg::FRAME_W-1:0]   rsp_frame_no,
   input logic [bfa_pkg::STATUS_W-1:0]  rsp_status
);

   // The map is being cleared right after reset, so no request is taken then.
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request ready right after reset");

   // Requests are served one at a time: no transfer in the cycle after one.
   assert property (@(posedge clock) disable iff (reset)
                    (req_valid && req_ready) |=> !req_ready)
      else $error("request taken in back-to-back cycles");

   // A full pool reports frame number zero.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp_status == bfa_pkg::STAT_FULL) |-> rsp_frame_no == '0)
      else $error("pool-full response with nonzero frame number");

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && !rsp_ready) |=>
                    (rsp_valid && $stable(rsp_frame_no) && $stable(rsp_status)))
      else $error("stalled response changed");

endmodule

bind bitmap_frame_allocator_unit bfa_checker u_bfa_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_frame_no (rsp_bus.frame_no),
   .rsp_status   (rsp_bus.status)
);
